// ===== hdl/separation_breach_interval_macros.svh =====
// Assertion macros shared by the separation breach interval RTL.
// Every macro expects clk and rst_n in scope; no other dependencies.
`ifndef SEPARATION_BREACH_INTERVAL_MACROS_SVH
`define SEPARATION_BREACH_INTERVAL_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SBI_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SBI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sbi_pkg.sv =====
// Shared widths, reset values and sideband type of the separation breach interval.
// No dependencies; imported by every module of the block.
package sbi_pkg;

  localparam int POS_W    = 20;
  localparam int VEL_W    = 12;
  localparam int THR_W    = 20;
  localparam int TIME_W   = 48;
  localparam int DP_W     = POS_W + 1;   // position difference
  localparam int DV_W     = VEL_W + 1;   // velocity difference
  localparam int A_W      = 25;          // |v|^2
  localparam int B_W      = 35;          // 2(d.v), signed
  localparam int ABSB_W   = B_W - 1;
  localparam int D2_W     = 41;          // |d|^2
  localparam int C_W      = D2_W + 1;    // |d|^2 - thr^2, signed
  localparam int ABSC_W   = D2_W;
  localparam int ROOT_W   = 35;
  localparam int DISC_W   = 2 * ROOT_W;
  localparam int NUM_W    = 37;          // -B +/- s, signed
  localparam int DEN_W    = A_W + 1;     // 2A

  localparam logic [THR_W-1:0] THR_RESET = 20'd9260;
  localparam int TIME_FRAC_BITS_DEF = 8;

  typedef struct packed {
    logic signed [B_W-1:0] b;
    logic [A_W-1:0]        a;
    logic                  zero_a;
    logic                  near;
    logic                  noint;
  } side_t;

endpackage

// ===== hdl/sbi_front.sv =====
// Front end: differences, squares and products, then the discriminant B^2 - 4AC.
// Eight register stages; uses sbi_pkg.
module sbi_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic signed [sbi_pkg::POS_W-1:0]  first_pos_x,
  input  logic signed [sbi_pkg::POS_W-1:0]  first_pos_y,
  input  logic signed [sbi_pkg::VEL_W-1:0]  first_vel_x,
  input  logic signed [sbi_pkg::VEL_W-1:0]  first_vel_y,
  input  logic signed [sbi_pkg::POS_W-1:0]  second_pos_x,
  input  logic signed [sbi_pkg::POS_W-1:0]  second_pos_y,
  input  logic signed [sbi_pkg::VEL_W-1:0]  second_vel_x,
  input  logic signed [sbi_pkg::VEL_W-1:0]  second_vel_y,
  input  logic [sbi_pkg::THR_W-1:0]         thr,
  output logic                              out_valid,
  output logic [sbi_pkg::DISC_W-1:0]        out_disc,
  output sbi_pkg::side_t                    out_side
);
  import sbi_pkg::*;

  localparam int NSTG  = 8;
  localparam int VSQ_W = 24;
  localparam int DSQ_W = 40;
  localparam int DVP_W = DP_W + DV_W;
  localparam int BLO_W = 32;
  localparam int BHI_W = ABSB_W - BLO_W;
  localparam int CLO_W = 21;
  localparam int CHI_W = ABSC_W - CLO_W;

  logic [NSTG-1:0] vld_r;

  logic signed [DP_W-1:0] dx_r, dy_r;
  logic signed [DV_W-1:0] vx_r, vy_r;

  logic signed [2*DV_W-1:0] vxx_c, vyy_c;
  logic signed [2*DP_W-1:0] dxx_c, dyy_c;
  logic [VSQ_W-1:0]         vxx_r, vyy_r;
  logic [DSQ_W-1:0]         dxx_r, dyy_r;
  logic signed [DVP_W-1:0]  dxvx_r, dyvy_r;
  logic [2*THR_W-1:0]       thr2_r, thr2_3r;

  logic [A_W-1:0]         a_r;
  logic [D2_W-1:0]        d2_r;
  logic signed [B_W-1:0]  b_r;

  logic signed [C_W-1:0]  c_c, c_r, nc_c;
  logic signed [B_W-1:0]  nb_c;
  logic [ABSB_W-1:0]      absb_r, absb5_r;
  logic [ABSC_W-1:0]      absc_r;
  logic                   cneg_r, cneg6_r, cneg7_r;

  logic [2*BHI_W-1:0]        bb_hh_r;
  logic [BHI_W+BLO_W-1:0]    bb_hl_r;
  logic [2*BLO_W-1:0]        bb_ll_r;
  logic [A_W+CLO_W-1:0]      ac_lo_r;
  logic [A_W+CHI_W-1:0]      ac_hi_r;

  logic [DISC_W-1:0] bsq_r, fac_r, disc_r;
  side_t s4_r, s5_r, s6_r, s7_r, s8_r;

  assign vxx_c = vx_r * vx_r;
  assign vyy_c = vy_r * vy_r;
  assign dxx_c = dx_r * dx_r;
  assign dyy_c = dy_r * dy_r;
  assign c_c   = $signed({1'b0, d2_r}) - $signed({2'b00, thr2_3r});
  assign nb_c  = -b_r;
  assign nc_c  = -c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    // Stage 1: differences.
    dx_r <= DP_W'(first_pos_x) - DP_W'(second_pos_x);
    dy_r <= DP_W'(first_pos_y) - DP_W'(second_pos_y);
    vx_r <= DV_W'(first_vel_x) - DV_W'(second_vel_x);
    vy_r <= DV_W'(first_vel_y) - DV_W'(second_vel_y);
    // Stage 2: products; all squares are non-negative and fit the narrower registers.
    vxx_r  <= vxx_c[VSQ_W-1:0];
    vyy_r  <= vyy_c[VSQ_W-1:0];
    dxx_r  <= dxx_c[DSQ_W-1:0];
    dyy_r  <= dyy_c[DSQ_W-1:0];
    dxvx_r <= dx_r * vx_r;
    dyvy_r <= dy_r * vy_r;
    thr2_r <= thr * thr;
    // Stage 3: sums.
    a_r     <= A_W'({1'b0, vxx_r}) + A_W'({1'b0, vyy_r});
    d2_r    <= D2_W'({1'b0, dxx_r}) + D2_W'({1'b0, dyy_r});
    b_r     <= (B_W'(dxvx_r) + B_W'(dyvy_r)) <<< 1;
    thr2_3r <= thr2_r;
    // Stage 4: C, magnitude of B and the zero-velocity flags.
    c_r       <= c_c;
    absb_r    <= b_r[B_W-1] ? nb_c[ABSB_W-1:0] : b_r[ABSB_W-1:0];
    s4_r      <= '{b: b_r, a: a_r, zero_a: (a_r == '0),
                   near: (d2_r <= D2_W'(thr2_3r)), noint: 1'b0};
    // Stage 5: magnitude of C.
    cneg_r  <= c_r[C_W-1];
    absc_r  <= c_r[C_W-1] ? nc_c[ABSC_W-1:0] : c_r[ABSC_W-1:0];
    absb5_r <= absb_r;
    s5_r    <= s4_r;
    // Stage 6: partial products of B^2 and A|C|.
    bb_hh_r <= absb5_r[ABSB_W-1:BLO_W] * absb5_r[ABSB_W-1:BLO_W];
    bb_hl_r <= absb5_r[ABSB_W-1:BLO_W] * absb5_r[BLO_W-1:0];
    bb_ll_r <= absb5_r[BLO_W-1:0] * absb5_r[BLO_W-1:0];
    ac_lo_r <= s5_r.a * absc_r[CLO_W-1:0];
    ac_hi_r <= s5_r.a * absc_r[ABSC_W-1:CLO_W];
    cneg6_r <= cneg_r;
    s6_r    <= s5_r;
    // Stage 7: assemble B^2 and 4A|C|; the cross term of B^2 appears twice.
    bsq_r   <= (DISC_W'(bb_hh_r) << (2*BLO_W)) + (DISC_W'(bb_hl_r) << (BLO_W+1))
               + DISC_W'(bb_ll_r);
    fac_r   <= (DISC_W'(ac_hi_r) << (CLO_W+2)) + (DISC_W'(ac_lo_r) << 2);
    cneg7_r <= cneg6_r;
    s7_r    <= s6_r;
    // Stage 8: discriminant.
    disc_r     <= cneg7_r ? (bsq_r + fac_r) : (bsq_r - fac_r);
    s8_r       <= '{b: s7_r.b, a: s7_r.a, zero_a: s7_r.zero_a, near: s7_r.near,
                    noint: (!cneg7_r && (fac_r > bsq_r))};
  end

  assign out_valid = vld_r[NSTG-1];
  assign out_disc  = disc_r;
  assign out_side  = s8_r;

endmodule

// ===== hdl/sbi_sqrt.sv =====
// Pipelined integer square root, one root bit per register stage.
// Carries the item's sideband alongside; uses sbi_pkg.
module sbi_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [sbi_pkg::DISC_W-1:0]  in_disc,
  input  sbi_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic [sbi_pkg::ROOT_W-1:0]  out_root,
  output sbi_pkg::side_t              out_side
);
  import sbi_pkg::*;

  localparam int NSTEP = ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic              vld_r  [NSTEP];
  logic [DISC_W-1:0] x_r    [NSTEP];
  logic [ROOT_W-1:0] q_r    [NSTEP];
  logic [REM_W-1:0]  rem_r  [NSTEP];
  side_t             side_r [NSTEP];

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    logic              v_in;
    logic [DISC_W-1:0] x_in;
    logic [ROOT_W-1:0] q_in;
    logic [REM_W-1:0]  rem_in;
    side_t             side_in;
    logic [REM_W+1:0]  rs, trial, diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign x_in    = in_disc;
      assign q_in    = '0;
      assign rem_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = vld_r[k-1];
      assign x_in    = x_r[k-1];
      assign q_in    = q_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign side_in = side_r[k-1];
    end

    // Bring down the next two radicand bits and try the digit one.
    assign rs    = {rem_in, x_in[DISC_W-1 -: 2]};
    assign trial = (REM_W+2)'({q_in, 2'b01});
    assign ge    = (rs >= trial);
    assign diff  = rs - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      x_r[k]    <= x_in << 2;
      q_r[k]    <= {q_in[ROOT_W-2:0], ge};
      rem_r[k]  <= ge ? diff[REM_W-1:0] : rs[REM_W-1:0];
      side_r[k] <= side_in;
    end
  end

  assign out_valid = vld_r[NSTEP-1];
  assign out_root  = q_r[NSTEP-1];
  assign out_side  = side_r[NSTEP-1];

endmodule

// ===== hdl/sbi_div.sv =====
// Pipelined restoring divider for unsigned operands, one quotient bit per stage.
// A tag rides along with each item; uses sbi_pkg only for the common import style.
module sbi_div #(
  parameter int DVD_W = 45,
  parameter int DEN_W = 26,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [DVD_W-1:0] in_dvd,
  input  logic [DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [DVD_W-1:0] out_quo,
  output logic [TAG_W-1:0] out_tag
);
  import sbi_pkg::*;

  logic             vld_r [DVD_W];
  logic [DVD_W-1:0] dq_r  [DVD_W];   // dividend bits shift out, quotient bits shift in
  logic [DEN_W-1:0] rem_r [DVD_W];
  logic [DEN_W-1:0] den_r [DVD_W];
  logic [TAG_W-1:0] tag_r [DVD_W];

  for (genvar k = 0; k < DVD_W; k++) begin : g_stage
    logic             v_in;
    logic [DVD_W-1:0] dq_in;
    logic [DEN_W-1:0] rem_in, den_in;
    logic [TAG_W-1:0] tag_in;
    logic [DEN_W:0]   rs, diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign dq_in  = in_dvd;
      assign rem_in = '0;
      assign den_in = in_den;
      assign tag_in = in_tag;
    end else begin : g_next
      assign v_in   = vld_r[k-1];
      assign dq_in  = dq_r[k-1];
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign tag_in = tag_r[k-1];
    end

    assign rs   = {rem_in, dq_in[DVD_W-1]};
    assign ge   = (rs >= {1'b0, den_in});
    assign diff = rs - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      dq_r[k]  <= {dq_in[DVD_W-2:0], ge};
      rem_r[k] <= ge ? diff[DEN_W-1:0] : rs[DEN_W-1:0];
      den_r[k] <= den_in;
      tag_r[k] <= tag_in;
    end
  end

  assign out_valid = vld_r[DVD_W-1];
  assign out_quo   = dq_r[DVD_W-1];
  assign out_tag   = tag_r[DVD_W-1];

endmodule

// ===== hdl/separation_breach_interval.sv =====
// Separation breach interval. A new target pair is taken every clock cycle and busy
// never rises. Each item yields one result on out_strobe after passing through
// 8 front-end stages, 35 square-root stages, 3 numerator stages, 37 + TIME_FRAC_BITS
// stages in each of the two dividers, and the output register. The divider length
// follows the time resolution. Results cannot be held off, so a receiver must take
// every strobe. The threshold register may only be written with no item in flight.
// Depends on sbi_pkg, sbi_front, sbi_sqrt, sbi_div and the macros header.
module separation_breach_interval #(
  parameter int TIME_FRAC_BITS = sbi_pkg::TIME_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [sbi_pkg::POS_W-1:0]  in_first_pos_x,
  input  logic signed [sbi_pkg::POS_W-1:0]  in_first_pos_y,
  input  logic signed [sbi_pkg::VEL_W-1:0]  in_first_vel_x,
  input  logic signed [sbi_pkg::VEL_W-1:0]  in_first_vel_y,
  input  logic signed [sbi_pkg::POS_W-1:0]  in_second_pos_x,
  input  logic signed [sbi_pkg::POS_W-1:0]  in_second_pos_y,
  input  logic signed [sbi_pkg::VEL_W-1:0]  in_second_vel_x,
  input  logic signed [sbi_pkg::VEL_W-1:0]  in_second_vel_y,
  input  logic                              cfg_wr_en,
  input  logic [sbi_pkg::THR_W-1:0]         cfg_wr_data,
  output logic                              out_strobe,
  output logic                              out_has_interval,
  output logic                              out_constant_distance,
  output logic signed [sbi_pkg::TIME_W-1:0] out_enter_time,
  output logic signed [sbi_pkg::TIME_W-1:0] out_exit_time
);
  import sbi_pkg::*;
  `include "separation_breach_interval_macros.svh"

  localparam int ABSN_W = NUM_W - 1;
  localparam int DVD_W  = NUM_W + TIME_FRAC_BITS;
  localparam logic [63:0] SAT_POS = (64'd1 << (TIME_W-1)) - 64'd1;
  localparam logic [63:0] SAT_NEG = 64'd1 << (TIME_W-1);

  typedef struct packed {
    logic zero_a;
    logic near;
    logic noint;
    logic neg;
  } lo_tag_t;

  logic [THR_W-1:0] thr_r;

  logic              fe_valid;
  logic [DISC_W-1:0] fe_disc;
  side_t             fe_side;
  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  side_t             sq_side;

  logic                   t1_vld_r, t2_vld_r, t3_vld_r;
  logic signed [NUM_W-1:0] nlo_r, nhi_r;
  logic signed [NUM_W-1:0] b_ext, s_ext, nlo_neg, nhi_neg;
  logic [DEN_W-1:0]       den1_r, den2_r, den3_r;
  side_t                  t1_side_r, t2_side_r;
  logic [ABSN_W-1:0]      alo_r, ahi_r;
  logic                   neg_lo_r, neg_hi_r;
  logic [DVD_W-1:0]       mlo_r, mhi_r;
  lo_tag_t                tag_lo_r, tag_lo_q;

  logic             dlo_valid, dhi_valid;
  logic [DVD_W-1:0] qlo, qhi;
  logic [0:0]       tag_hi_r, tag_hi_q;

  logic                     strobe_r, has_r, cd_r;
  logic signed [TIME_W-1:0] enter_r, exit_r;

  function automatic logic [TIME_W-1:0] to_time(input logic [DVD_W-1:0] q,
                                                 input logic neg);
    logic [63:0] m;
    logic [63:0] r;
    m = 64'(q);
    if (neg) begin
      r = (m > SAT_NEG) ? SAT_NEG : m;
      r = 64'd0 - r;
    end else begin
      r = (m > SAT_POS) ? SAT_POS : m;
    end
    return r[TIME_W-1:0];
  endfunction

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  sbi_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (start & ~busy),
    .first_pos_x  (in_first_pos_x),
    .first_pos_y  (in_first_pos_y),
    .first_vel_x  (in_first_vel_x),
    .first_vel_y  (in_first_vel_y),
    .second_pos_x (in_second_pos_x),
    .second_pos_y (in_second_pos_y),
    .second_vel_x (in_second_vel_x),
    .second_vel_y (in_second_vel_y),
    .thr          (thr_r),
    .out_valid    (fe_valid),
    .out_disc     (fe_disc),
    .out_side     (fe_side)
  );

  sbi_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fe_valid),
    .in_disc   (fe_disc),
    .in_side   (fe_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  assign b_ext   = NUM_W'(sq_side.b);
  assign s_ext   = $signed({2'b00, sq_root});
  assign nlo_neg = -nlo_r;
  assign nhi_neg = -nhi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_vld_r <= 1'b0;
      t2_vld_r <= 1'b0;
      t3_vld_r <= 1'b0;
    end else begin
      t1_vld_r <= sq_valid;
      t2_vld_r <= t1_vld_r;
      t3_vld_r <= t2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    // Numerators -B - s and -B + s, divisor 2A.
    nlo_r     <= -b_ext - s_ext;
    nhi_r     <= -b_ext + s_ext;
    den1_r    <= {sq_side.a, 1'b0};
    t1_side_r <= sq_side;
    // Magnitudes.
    neg_lo_r  <= nlo_r[NUM_W-1];
    neg_hi_r  <= nhi_r[NUM_W-1];
    alo_r     <= nlo_r[NUM_W-1] ? nlo_neg[ABSN_W-1:0] : nlo_r[ABSN_W-1:0];
    ahi_r     <= nhi_r[NUM_W-1] ? nhi_neg[ABSN_W-1:0] : nhi_r[ABSN_W-1:0];
    den2_r    <= den1_r;
    t2_side_r <= t1_side_r;
    // Scale to the time resolution. A negative numerator is rounded up in magnitude
    // so that the negated quotient is the floor.
    mlo_r <= (DVD_W'(alo_r) << TIME_FRAC_BITS)
             + (neg_lo_r ? (DVD_W'(den2_r) - DVD_W'(1)) : DVD_W'(0));
    mhi_r <= (DVD_W'(ahi_r) << TIME_FRAC_BITS)
             + (neg_hi_r ? (DVD_W'(den2_r) - DVD_W'(1)) : DVD_W'(0));
    den3_r    <= den2_r;
    tag_lo_r  <= '{zero_a: t2_side_r.zero_a, near: t2_side_r.near,
                   noint: t2_side_r.noint, neg: neg_lo_r};
    tag_hi_r  <= neg_hi_r;
  end

  sbi_div #(
    .DVD_W (DVD_W),
    .DEN_W (DEN_W),
    .TAG_W ($bits(lo_tag_t))
  ) u_div_enter (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (t3_vld_r),
    .in_dvd    (mlo_r),
    .in_den    (den3_r),
    .in_tag    (tag_lo_r),
    .out_valid (dlo_valid),
    .out_quo   (qlo),
    .out_tag   (tag_lo_q)
  );

  sbi_div #(
    .DVD_W (DVD_W),
    .DEN_W (DEN_W),
    .TAG_W (1)
  ) u_div_exit (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (t3_vld_r),
    .in_dvd    (mhi_r),
    .in_den    (den3_r),
    .in_tag    (tag_hi_r),
    .out_valid (dhi_valid),
    .out_quo   (qhi),
    .out_tag   (tag_hi_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= dlo_valid;
    end
  end

  // With zero relative velocity the quotients are meaningless and only the
  // distance test counts.
  always_ff @(posedge clk) begin
    has_r <= tag_lo_q.zero_a ? tag_lo_q.near : !tag_lo_q.noint;
    cd_r  <= tag_lo_q.zero_a & tag_lo_q.near;
    if (tag_lo_q.zero_a || tag_lo_q.noint) begin
      enter_r <= '0;
      exit_r  <= '0;
    end else begin
      enter_r <= to_time(qlo, tag_lo_q.neg);
      exit_r  <= to_time(qhi, tag_hi_q[0]);
    end
  end

  assign out_strobe            = strobe_r;
  assign out_has_interval      = has_r;
  assign out_constant_distance = cd_r;
  assign out_enter_time        = enter_r;
  assign out_exit_time         = exit_r;

  `SBI_ASSERT(a_div_lockstep, dlo_valid || dhi_valid, dlo_valid && dhi_valid,
              "dividers out of step")
  `SBI_ASSERT_NEXT(a_strobe_follows, dlo_valid, out_strobe, "result strobe lost")
  `SBI_ASSERT(a_cd_has, out_strobe && out_constant_distance, out_has_interval,
              "constant distance without interval")
  `SBI_ASSERT(a_no_interval_zero, out_strobe && !out_has_interval,
              out_enter_time == '0 && out_exit_time == '0, "times set without interval")
  `SBI_ASSERT(a_order, out_strobe && out_has_interval && !out_constant_distance,
              out_enter_time <= out_exit_time, "enter time after exit time")

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for separation_breach_interval: random and directed target pairs
// are checked against an in-bench prediction of the crossing interval.
// Depends on sbi_pkg and the separation_breach_interval RTL.
`timescale 1ns / 1ps

module testbench;
  import sbi_pkg::*;

  typedef enum int { K_PAIR, K_THR, K_DRAIN } entry_kind_t;

  typedef struct {
    entry_kind_t             kind;
    int                      gap;
    logic [THR_W-1:0]        thr;
    logic signed [POS_W-1:0] fpx, fpy, spx, spy;
    logic signed [VEL_W-1:0] fvx, fvy, svx, svy;
  } pair_entry_t;

  typedef struct {
    logic                     has_interval;
    logic                     constant_distance;
    logic signed [TIME_W-1:0] enter_time;
    logic signed [TIME_W-1:0] exit_time;
  } interval_t;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 120;
  localparam longint TIME_MAX = 64'sd140737488355327;
  localparam longint TIME_MIN = -64'sd140737488355328;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [POS_W-1:0] in_first_pos_x = '0, in_first_pos_y = '0;
  logic signed [POS_W-1:0] in_second_pos_x = '0, in_second_pos_y = '0;
  logic signed [VEL_W-1:0] in_first_vel_x = '0, in_first_vel_y = '0;
  logic signed [VEL_W-1:0] in_second_vel_x = '0, in_second_vel_y = '0;
  logic cfg_wr_en = 1'b0;
  logic [THR_W-1:0] cfg_wr_data = '0;
  logic out_strobe, out_has_interval, out_constant_distance;
  logic signed [TIME_W-1:0] out_enter_time, out_exit_time;

  pair_entry_t      pending_pairs[$];
  interval_t        expected_intervals[$];
  logic [THR_W-1:0] threshold_now = THR_RESET;
  bit               pair_taken = 0;
  int               gap_left = 0;
  int               idle_cycles = 0;
  int               error_count = 0;

  separation_breach_interval dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_first_pos_x(in_first_pos_x), .in_first_pos_y(in_first_pos_y),
    .in_first_vel_x(in_first_vel_x), .in_first_vel_y(in_first_vel_y),
    .in_second_pos_x(in_second_pos_x), .in_second_pos_y(in_second_pos_y),
    .in_second_vel_x(in_second_vel_x), .in_second_vel_y(in_second_vel_y),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_strobe(out_strobe), .out_has_interval(out_has_interval),
    .out_constant_distance(out_constant_distance),
    .out_enter_time(out_enter_time), .out_exit_time(out_exit_time)
  );

  always #4 clk = ~clk;

  function automatic longint crossing_time(longint num, longint den);
    longint n, q;
    n = num * 256;
    q = n / den;
    if (n % den != 0 && n < 0) q = q - 1;
    if (q > TIME_MAX) q = TIME_MAX;
    if (q < TIME_MIN) q = TIME_MIN;
    return q;
  endfunction

  function automatic interval_t predict_breach(pair_entry_t p, logic [THR_W-1:0] thr);
    longint dx, dy, vx, vy, a, d2, b, c, thr2, s;
    logic [79:0] bsq, fac, disc, t;
    interval_t r;
    dx = longint'(p.fpx) - longint'(p.spx);
    dy = longint'(p.fpy) - longint'(p.spy);
    vx = longint'(p.fvx) - longint'(p.svx);
    vy = longint'(p.fvy) - longint'(p.svy);
    thr2 = longint'(thr) * longint'(thr);
    a = vx * vx + vy * vy;
    d2 = dx * dx + dy * dy;
    r = '{1'b0, 1'b0, '0, '0};
    if (a == 0) begin
      r.has_interval = (d2 <= thr2);
      r.constant_distance = (d2 <= thr2);
      return r;
    end
    b = 2 * (dx * vx + dy * vy);
    c = d2 - thr2;
    bsq = 80'(b < 0 ? -b : b) * 80'(b < 0 ? -b : b);
    fac = 80'(4 * a) * 80'(c < 0 ? -c : c);
    if (c < 0) begin
      disc = bsq + fac;
    end else begin
      if (fac > bsq) return r;
      disc = bsq - fac;
    end
    s = 0;
    for (int bit_i = 35; bit_i >= 0; bit_i--) begin
      t = 80'(s) | (80'd1 << bit_i);
      if (t * t <= disc) s = longint'(t);
    end
    r.has_interval = 1'b1;
    r.enter_time = crossing_time(-b - s, 2 * a);
    r.exit_time = crossing_time(-b + s, 2 * a);
    return r;
  endfunction

  // Driver: everything changes at the falling edge, one assignment per signal.
  always @(negedge clk) begin
    logic nxt_start, nxt_cfg;
    nxt_start = start;
    nxt_cfg = 1'b0;
    if (rst_n && !(start && !pair_taken)) begin
      nxt_start = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_pairs.size() > 0) begin
        case (pending_pairs[0].kind)
          K_PAIR: begin
            in_first_pos_x <= pending_pairs[0].fpx;
            in_first_pos_y <= pending_pairs[0].fpy;
            in_first_vel_x <= pending_pairs[0].fvx;
            in_first_vel_y <= pending_pairs[0].fvy;
            in_second_pos_x <= pending_pairs[0].spx;
            in_second_pos_y <= pending_pairs[0].spy;
            in_second_vel_x <= pending_pairs[0].svx;
            in_second_vel_y <= pending_pairs[0].svy;
            nxt_start = 1'b1;
            gap_left = pending_pairs[0].gap;
            void'(pending_pairs.pop_front());
          end
          K_THR: begin
            if (expected_intervals.size() == 0) begin
              cfg_wr_data <= pending_pairs[0].thr;
              nxt_cfg = 1'b1;
              void'(pending_pairs.pop_front());
            end
          end
          default: begin
            if (expected_intervals.size() == 0) void'(pending_pairs.pop_front());
          end
        endcase
      end
    end
    start <= nxt_start;
    cfg_wr_en <= nxt_cfg;
  end

  // Monitor: records accepted items and checks every strobed result.
  always @(posedge clk) begin
    pair_entry_t p;
    interval_t e;
    pair_taken = 0;
    if (rst_n) begin
      idle_cycles++;
      if (start && !busy) begin
        p.fpx = in_first_pos_x;   p.fpy = in_first_pos_y;
        p.fvx = in_first_vel_x;   p.fvy = in_first_vel_y;
        p.spx = in_second_pos_x;  p.spy = in_second_pos_y;
        p.svx = in_second_vel_x;  p.svy = in_second_vel_y;
        expected_intervals.push_back(predict_breach(p, threshold_now));
        pair_taken = 1;
        idle_cycles = 0;
      end
      if (cfg_wr_en) threshold_now = cfg_wr_data;
      if (out_strobe) begin
        idle_cycles = 0;
        if (expected_intervals.size() == 0) begin
          $error("result with no item outstanding");
          error_count++;
        end else begin
          e = expected_intervals.pop_front();
          if (out_has_interval !== e.has_interval) begin
            $error("has_interval: expected %0d, got %0d", e.has_interval, out_has_interval);
            error_count++;
          end
          if (out_constant_distance !== e.constant_distance) begin
            $error("constant_distance: expected %0d, got %0d",
                   e.constant_distance, out_constant_distance);
            error_count++;
          end
          if (out_enter_time !== e.enter_time) begin
            $error("enter_time: expected %0d, got %0d", e.enter_time, out_enter_time);
            error_count++;
          end
          if (out_exit_time !== e.exit_time) begin
            $error("exit_time: expected %0d, got %0d", e.exit_time, out_exit_time);
            error_count++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  function automatic pair_entry_t make_pair(int fx, int fy, int fvx, int fvy,
                                            int sx, int sy, int svx, int svy, int gap);
    pair_entry_t p;
    p.kind = K_PAIR;
    p.gap = gap;
    p.thr = '0;
    p.fpx = POS_W'(fx);  p.fpy = POS_W'(fy);  p.fvx = VEL_W'(fvx);  p.fvy = VEL_W'(fvy);
    p.spx = POS_W'(sx);  p.spy = POS_W'(sy);  p.svx = VEL_W'(svx);  p.svy = VEL_W'(svy);
    return p;
  endfunction

  function automatic pair_entry_t random_pair(int gap);
    pair_entry_t p;
    int fx, fy, vx, vy, sel;
    sel = $urandom_range(0, 9);
    fx = $signed(POS_W'($urandom));
    fy = $signed(POS_W'($urandom));
    if (sel < 3) begin
      // Unrelated targets anywhere in the field.
      p = make_pair(fx, fy, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, gap);
    end else if (sel < 4) begin
      // Same velocity: only the constant distance test applies.
      vx = $urandom; vy = $urandom;
      p = make_pair(fx, fy, vx, vy, fx + $urandom_range(0, 40000) - 20000,
                    fy + $urandom_range(0, 40000) - 20000, vx, vy, gap);
    end else begin
      // Nearby targets heading roughly toward each other.
      vx = $urandom_range(0, 600) - 300; vy = $urandom_range(0, 600) - 300;
      p = make_pair(fx, fy, vx, vy, fx + $urandom_range(0, 100000) - 50000,
                    fy + $urandom_range(0, 100000) - 50000,
                    -vx + $urandom_range(0, 60) - 30, -vy + $urandom_range(0, 60) - 30,
                    gap);
    end
    return p;
  endfunction

  initial begin
    pair_entry_t ctl;
    logic [THR_W-1:0] thr_plan[5];
    bit burst;
    thr_plan = '{THR_RESET, 20'd0, 20'hFFFFF, 20'($urandom_range(1, 200000)), 20'd9260};
    ctl = make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0);

    // Zero relative velocity: inside, on and beyond the threshold.
    pending_pairs.push_back(make_pair(0, 0, 5, 5, 100, 0, 5, 5, 0));
    pending_pairs.push_back(make_pair(9260, 0, -7, 3, 0, 0, -7, 3, 1));
    pending_pairs.push_back(make_pair(9261, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(524287, 524287, 2047, 2047,
                                      -524288, -524288, 2047, 2047, 2));
    // Touching: closest approach exactly at the threshold.
    pending_pairs.push_back(make_pair(9260, 0, 0, 1, 0, 0, 0, 0, 0));
    // No solution: passes well clear.
    pending_pairs.push_back(make_pair(20000, 0, 0, 5, 0, 0, 0, 0, 0));
    // Head-on approaches and separations, extremes of every field.
    pending_pairs.push_back(make_pair(-50000, 0, 250, 0, 0, 0, 0, 0, 3));
    pending_pairs.push_back(make_pair(100, 100, 1, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(524287, -524288, 2047, -2048,
                                      -524288, 524287, -2048, 2047, 0));
    pending_pairs.push_back(make_pair(-524288, 524287, -2048, 2047,
                                      524287, -524288, 2047, -2048, 5));
    pending_pairs.push_back(make_pair(524287, 524287, -2048, -2048,
                                      -524288, -524288, 2047, 2047, 0));
    pending_pairs.push_back(make_pair(0, 0, 2047, 2047, 0, 0, -2048, -2048, 0));
    pending_pairs.push_back(make_pair(0, 0, 1, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(-3, 7, -1, 2, 4, -1, 0, 0, 1));

    foreach (thr_plan[ph]) begin
      if (ph > 0) begin
        ctl.kind = K_THR;
        ctl.thr = thr_plan[ph];
        pending_pairs.push_back(ctl);
      end
      burst = 0;
      for (int n = 0; n < 130; n++) begin
        if (n % 25 == 0) burst = $urandom_range(0, 1);
        pending_pairs.push_back(random_pair(burst ? 0 : $urandom_range(0, 5)));
        if (ph == 1 && n == 60) begin
          ctl.kind = K_DRAIN;
          pending_pairs.push_back(ctl);
        end
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_pairs.size() > 0 || expected_intervals.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/sbi_pkg.sv
hdl/sbi_front.sv
hdl/sbi_sqrt.sv
hdl/sbi_div.sv
hdl/separation_breach_interval.sv
bench/testbench.sv
